>>> sv/ifp_pkg.sv
// ----------------------------------------------------------------------------
// ifp_pkg
// Shared types, constants and frame classification for the IMU frame parser.
// ----------------------------------------------------------------------------
package ifp_pkg;

	// frame layout
	localparam logic [3:0] HELD_MAX    = 4'd10;
	localparam int         NUM_WORDS   = 4;
	localparam logic [7:0] SYNC_BYTE   = 8'h55;
	localparam logic [7:0] TYPE_MASK   = 8'h50;

	// frame type bytes
	localparam logic [7:0] TYPE_ACCEL  = 8'h51;
	localparam logic [7:0] TYPE_GYRO   = 8'h52;
	localparam logic [7:0] TYPE_ANGLE  = 8'h53;
	localparam logic [7:0] TYPE_MAG    = 8'h54;
	localparam logic [7:0] TYPE_QUAT   = 8'h59;

	// result status codes
	localparam logic [1:0] ST_DECODED  = 2'd0;
	localparam logic [1:0] ST_REJECT   = 2'd1;
	localparam logic [1:0] ST_UNKNOWN  = 2'd2;

	// result kind codes
	localparam logic [2:0] KIND_ACCEL  = 3'd0;
	localparam logic [2:0] KIND_GYRO   = 3'd1;
	localparam logic [2:0] KIND_ANGLE  = 3'd2;
	localparam logic [2:0] KIND_MAG    = 3'd3;
	localparam logic [2:0] KIND_QUAT   = 3'd4;

	// configuration register indexes
	localparam logic [2:0] REG_ACCEL   = 3'd0;
	localparam logic [2:0] REG_GYRO    = 3'd1;
	localparam logic [2:0] REG_ANGLE   = 3'd2;
	localparam logic [2:0] REG_MAG     = 3'd3;
	localparam logic [2:0] REG_QUAT    = 3'd4;

	// scale reset values
	localparam logic [15:0] ACCEL_SCALE_RST = 16'd16;
	localparam logic [15:0] GYRO_SCALE_RST  = 16'd2000;
	localparam logic [15:0] ANGLE_SCALE_RST = 16'd180;
	localparam logic [15:0] MAG_SCALE_RST   = 16'd32768;
	localparam logic [15:0] QUAT_SCALE_RST  = 16'd1;

	// depth of the queue between front and back
	localparam int QUEUE_DEPTH = 2;

	typedef struct packed {
		logic [15:0] accel;
		logic [15:0] gyro;
		logic [15:0] angle;
		logic [15:0] mag;
		logic [15:0] quat;
	} ifp_scales_t;

	// classified frame waiting for the multipliers
	typedef struct packed {
		logic [1:0]                  status;
		logic [2:0]                  kind;
		logic [NUM_WORDS-1:0][15:0]  words;
	} ifp_item_t;

	typedef struct packed {
		logic       known;
		logic [2:0] kind;
	} ifp_class_t;

	function automatic ifp_class_t classify(input logic [7:0] type_byte);
		ifp_class_t c;
		c.known = 1'b1;
		c.kind  = KIND_ACCEL;
		case (type_byte)
			TYPE_ACCEL: c.kind = KIND_ACCEL;
			TYPE_GYRO:  c.kind = KIND_GYRO;
			TYPE_ANGLE: c.kind = KIND_ANGLE;
			TYPE_MAG:   c.kind = KIND_MAG;
			TYPE_QUAT:  c.kind = KIND_QUAT;
			default:    c.known = 1'b0;
		endcase
		return c;
	endfunction

endpackage

>>> sv/ifp_front.sv
// ----------------------------------------------------------------------------
// ifp_front
// Byte window, running checksum and frame classification.
// ----------------------------------------------------------------------------
module ifp_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [7:0]        rx_byte,
	output logic              full,
	input  logic              q_full,
	output logic              q_push,
	output ifp_pkg::ifp_item_t q_item
);
	import ifp_pkg::*;

	logic [7:0] win_q [HELD_MAX];
	logic [3:0] fill_q;
	logic [7:0] sum_q;
	logic       accept;
	logic       win_full;
	logic       frame_ok;
	ifp_class_t cls;

	always_comb begin
		full     = q_full;
		accept   = push & ~full;
		win_full = (fill_q >= HELD_MAX);
		frame_ok = (win_q[0] == SYNC_BYTE) && ((win_q[1] & TYPE_MASK) == TYPE_MASK)
			&& (sum_q == rx_byte);
		cls      = classify(win_q[1]);
		q_push   = accept & win_full;
		q_item.kind = KIND_ACCEL;
		for (int k = 0; k < NUM_WORDS; k++) begin
			q_item.words[k] = {win_q[3 + 2 * k], win_q[2 + 2 * k]};
		end
		if (!frame_ok) begin
			q_item.status = ST_REJECT;
		end else if (!cls.known) begin
			q_item.status = ST_UNKNOWN;
		end else begin
			q_item.status = ST_DECODED;
			q_item.kind   = cls.kind;
		end
	end

	// window payload: fill in order, then slide on reject
	always_ff @(posedge clk) begin
		if (accept) begin
			if (!win_full) begin
				win_q[fill_q] <= rx_byte;
			end else if (!frame_ok) begin
				for (int i = 0; i < HELD_MAX - 1; i++) begin
					win_q[i] <= win_q[i + 1];
				end
				win_q[HELD_MAX - 1] <= rx_byte;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			sum_q  <= '0;
		end else if (accept) begin
			if (!win_full) begin
				fill_q <= fill_q + 4'd1;
				sum_q  <= (fill_q == '0) ? rx_byte : sum_q + rx_byte;
			end else if (!frame_ok) begin
				// drop the oldest byte from the running sum
				sum_q  <= sum_q - win_q[0] + rx_byte;
			end else begin
				fill_q <= '0;
				sum_q  <= '0;
			end
		end
	end

`ifndef SYNTHESIS
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= HELD_MAX)
		else $error("window fill count above frame length");

	a_push_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> fill_q == HELD_MAX)
		else $error("frame classified before window was full");
`endif

endmodule

>>> sv/ifp_queue.sv
// ----------------------------------------------------------------------------
// ifp_queue
// Short first-in first-out queue of classified frames.
// ----------------------------------------------------------------------------
module ifp_queue #(
	parameter int DEPTH = ifp_pkg::QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  ifp_pkg::ifp_item_t wr_item,
	output logic               q_full,
	input  logic               rd_en,
	output logic               rd_valid,
	output ifp_pkg::ifp_item_t rd_item
);
	import ifp_pkg::*;

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	ifp_item_t      mem_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;
	logic           do_wr;
	logic           do_rd;

	always_comb begin
		q_full   = (count_q == CW'(DEPTH));
		rd_valid = (count_q != '0);
		rd_item  = mem_q[rd_ptr_q];
		do_wr    = wr_en & ~q_full;
		do_rd    = rd_en & rd_valid;
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue count above depth");

	a_count_grow: assert property (@(posedge clk) disable iff (!arst_n)
		(do_wr && !do_rd) |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count did not advance on write");
`endif

endmodule

>>> sv/ifp_back.sv
// ----------------------------------------------------------------------------
// ifp_back
// Scale multipliers and output register for classified frames.
// ----------------------------------------------------------------------------
module ifp_back (
	input  logic                clk,
	input  logic                arst_n,
	input  ifp_pkg::ifp_scales_t scales,
	input  logic                q_valid,
	input  ifp_pkg::ifp_item_t  q_item,
	output logic                q_pop,
	output logic                empty,
	input  logic                pop,
	output logic [1:0]          status,
	output logic [2:0]          kind,
	output logic signed [31:0]  value_zero,
	output logic signed [31:0]  value_one,
	output logic signed [31:0]  value_two,
	output logic signed [31:0]  value_three
);
	import ifp_pkg::*;

	logic                              vld_s1;
	logic [1:0]                        status_s1;
	logic [2:0]                        kind_s1;
	logic [NUM_WORDS-1:0][31:0]        val_s1;
	logic [NUM_WORDS-1:0][31:0]        val_d;
	logic [15:0]                       scale;
	logic                              advance;
	logic signed [32:0]                prod;

	always_comb begin
		case (q_item.kind)
			KIND_ACCEL: scale = scales.accel;
			KIND_GYRO:  scale = scales.gyro;
			KIND_ANGLE: scale = scales.angle;
			KIND_MAG:   scale = scales.mag;
			KIND_QUAT:  scale = scales.quat;
			default:    scale = '0;
		endcase
		for (int k = 0; k < NUM_WORDS; k++) begin
			prod = $signed(q_item.words[k]) * $signed({1'b0, scale});
			val_d[k] = prod[31:0];
			// zero the values of rejects, unknown types and the unused fourth word
			if (q_item.status != ST_DECODED
				|| (k == NUM_WORDS - 1 && q_item.kind != KIND_QUAT)) begin
				val_d[k] = '0;
			end
		end
		advance = ~vld_s1 | pop;
		q_pop   = q_valid & advance;
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			status_s1 <= q_item.status;
			kind_s1   <= (q_item.status == ST_DECODED) ? q_item.kind : KIND_ACCEL;
			val_s1    <= val_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (advance) begin
			vld_s1 <= q_valid;
		end
	end

	assign empty       = ~vld_s1;
	assign status      = status_s1;
	assign kind        = kind_s1;
	assign value_zero  = val_s1[0];
	assign value_one   = val_s1[1];
	assign value_two   = val_s1[2];
	assign value_three = val_s1[3];

`ifndef SYNTHESIS
	a_non_decoded_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && status_s1 != ST_DECODED) |-> (val_s1 == '0 && kind_s1 == KIND_ACCEL))
		else $error("reject or unknown result carries data");
`endif

endmodule

>>> sv/imu_frame_parser.sv
// ----------------------------------------------------------------------------
// imu_frame_parser
// Byte-serial parser for 11-byte sensor frames with a mod-256 sum checksum.
// ----------------------------------------------------------------------------
// Input channel: push a received byte on rx_byte while full is low; one byte
// can be taken every clock. The front keeps the last ten bytes and a running
// checksum; each byte after the tenth completes a candidate frame, which is
// classified in the same cycle and written to a short queue.
// Result channel: a result waits on the result ports while empty is low and
// leaves on pop. A frame result goes through the queue into the output
// register; bytes that only fill the window give none. Rejects (bad header
// or checksum) give status 1 and slide the window by one byte; unknown types
// give status 2 and clear it; decoded frames give signed Q16.15 values, each
// a signed 16-bit word times the scale of its frame type, the fourth zero but
// for quaternion frames. Throughput is one byte per cycle while full is low,
// set by the combinational classify and the four parallel 16x17 multipliers
// feeding the output register. When pop stays low the output register and
// queue fill, then full rises and holds the input side until results drain.
// Configuration: write a scale through cfg_valid/cfg_index/cfg_data while idle.
// Reset empties the window, the queue and the output, and loads default scales.
// ----------------------------------------------------------------------------
module imu_frame_parser #(
	parameter int QDEPTH = ifp_pkg::QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [7:0]         rx_byte,
	output logic               empty,
	input  logic               pop,
	output logic [1:0]         status,
	output logic [2:0]         kind,
	output logic signed [31:0] value_zero,
	output logic signed [31:0] value_one,
	output logic signed [31:0] value_two,
	output logic signed [31:0] value_three,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data
);
	import ifp_pkg::*;

	ifp_scales_t scales_q;
	logic        q_full;
	logic        q_push;
	ifp_item_t   q_wr_item;
	logic        q_valid;
	logic        q_pop;
	ifp_item_t   q_rd_item;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scales_q.accel <= ACCEL_SCALE_RST;
			scales_q.gyro  <= GYRO_SCALE_RST;
			scales_q.angle <= ANGLE_SCALE_RST;
			scales_q.mag   <= MAG_SCALE_RST;
			scales_q.quat  <= QUAT_SCALE_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ACCEL: scales_q.accel <= cfg_data;
				REG_GYRO:  scales_q.gyro  <= cfg_data;
				REG_ANGLE: scales_q.angle <= cfg_data;
				REG_MAG:   scales_q.mag   <= cfg_data;
				REG_QUAT:  scales_q.quat  <= cfg_data;
				default: ;  // drop writes beyond the register list
			endcase
		end
	end

	ifp_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.rx_byte (rx_byte),
		.full    (full),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_item  (q_wr_item)
	);

	ifp_queue #(
		.DEPTH (QDEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (q_push),
		.wr_item  (q_wr_item),
		.q_full   (q_full),
		.rd_en    (q_pop),
		.rd_valid (q_valid),
		.rd_item  (q_rd_item)
	);

	ifp_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.scales      (scales_q),
		.q_valid     (q_valid),
		.q_item      (q_rd_item),
		.q_pop       (q_pop),
		.empty       (empty),
		.pop         (pop),
		.status      (status),
		.kind        (kind),
		.value_zero  (value_zero),
		.value_one   (value_one),
		.value_two   (value_two),
		.value_three (value_three)
	);

endmodule

>>> verif/imu_frame_parser_tb.sv
// ----------------------------------------------------------------------------
// imu_frame_parser_tb
// Streams sensor frames, broken frames and noise bytes into the parser through
// its byte input. A scoreboard mirrors the byte window and scale registers,
// and each popped result is checked field by field against the oldest
// expectation. Scales are rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module imu_frame_parser_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ifp_pkg::*;

	localparam int FRAME_LEN     = 11;
	localparam int NUM_SCALES    = 5;
	localparam int REG_SPACE     = 8;
	localparam int SETTLE_CYCLES = 8;
	localparam int DRAIN_LIMIT   = 5000;
	localparam int REPORT_LIMIT  = 10;
	localparam int NUM_PHASES    = 7;
	localparam int PHASE_BYTES   = 200;
	localparam logic [7:0] TYPE_ALL_ONES = 8'hFF;

	typedef struct packed {
		logic [1:0]                 status;
		logic [2:0]                 kind;
		logic [NUM_WORDS-1:0][31:0] value;
	} frame_result_t;

	typedef enum {FAULT_NONE, FAULT_SUM, FAULT_SYNC, FAULT_TYPE} frame_fault_t;
	typedef logic [FRAME_LEN-1:0][7:0] frame_bytes_t;
	typedef logic [NUM_WORDS-1:0][15:0] frame_words_t;
	typedef logic [15:0] scale_set_t [NUM_SCALES];

	class frame_scoreboard;
		logic [7:0]    window [HELD_MAX];
		int            held;
		logic [15:0]   scale_reg [NUM_SCALES];
		frame_result_t expected_q [$];
		int            failures;

		function new();
			held = 0;
			failures = 0;
			scale_reg[REG_ACCEL] = ACCEL_SCALE_RST;
			scale_reg[REG_GYRO]  = GYRO_SCALE_RST;
			scale_reg[REG_ANGLE] = ANGLE_SCALE_RST;
			scale_reg[REG_MAG]   = MAG_SCALE_RST;
			scale_reg[REG_QUAT]  = QUAT_SCALE_RST;
		endfunction

		function void set_scale(logic [2:0] idx, logic [15:0] data);
			if (idx <= REG_QUAT) begin
				scale_reg[idx] = data;
			end
		endfunction

		function void note_byte(logic [7:0] b);
			logic [7:0]    sum;
			logic [15:0]   scale;
			longint        prod;
			int            words;
			frame_result_t r;
			if (held < HELD_MAX) begin
				window[held] = b;
				held++;
				return;
			end
			sum = '0;
			foreach (window[i])
				sum += window[i];
			r = '0;
			if (window[0] != SYNC_BYTE || (window[1] & TYPE_MASK) != TYPE_MASK || sum != b) begin
				// drop the oldest byte, window stays full
				for (int i = 0; i < HELD_MAX - 1; i++)
					window[i] = window[i + 1];
				window[HELD_MAX - 1] = b;
				r.status = ST_REJECT;
				expected_q.push_back(r);
				return;
			end
			held = 0;
			words = NUM_WORDS - 1;
			scale = '0;
			case (window[1])
				TYPE_ACCEL: begin
					r.kind = KIND_ACCEL;
					scale = scale_reg[REG_ACCEL];
				end
				TYPE_GYRO: begin
					r.kind = KIND_GYRO;
					scale = scale_reg[REG_GYRO];
				end
				TYPE_ANGLE: begin
					r.kind = KIND_ANGLE;
					scale = scale_reg[REG_ANGLE];
				end
				TYPE_MAG: begin
					r.kind = KIND_MAG;
					scale = scale_reg[REG_MAG];
				end
				TYPE_QUAT: begin
					r.kind = KIND_QUAT;
					scale = scale_reg[REG_QUAT];
					words = NUM_WORDS;
				end
				default: r.status = ST_UNKNOWN;
			endcase
			if (r.status == ST_DECODED) begin
				for (int k = 0; k < words; k++) begin
					prod = longint'($signed({window[3 + 2*k], window[2 + 2*k]}))
						* longint'(scale);
					r.value[k] = prod[31:0];
				end
			end
			expected_q.push_back(r);
		endfunction

		function void flag(string what, longint want, longint got);
			failures++;
			if (failures <= REPORT_LIMIT)
				$display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
		endfunction

		function void check_result(frame_result_t got);
			frame_result_t want;
			if (expected_q.size() == 0) begin
				failures++;
				if (failures <= REPORT_LIMIT)
					$display("%0t: result with no frame pending, status %0d", $time, got.status);
				return;
			end
			want = expected_q.pop_front();
			if (got.status !== want.status)
				flag("status", want.status, got.status);
			if (got.kind !== want.kind)
				flag("kind", want.kind, got.kind);
			for (int k = 0; k < NUM_WORDS; k++) begin
				if (got.value[k] !== want.value[k])
					flag($sformatf("value %0d", k), $signed(want.value[k]),
						$signed(got.value[k]));
			end
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               push = 1'b0;
	logic               full;
	logic [7:0]         rx_byte = '0;
	logic               empty;
	logic               pop = 1'b0;
	logic [1:0]         status;
	logic [2:0]         kind;
	logic signed [31:0] value_zero;
	logic signed [31:0] value_one;
	logic signed [31:0] value_two;
	logic signed [31:0] value_three;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [2:0]         cfg_index = '0;
	logic [15:0]        cfg_data = '0;

	frame_scoreboard sb = new();
	int              bytes_sent = 0;
	bit              push_paced = 1'b0;
	logic [7:0]      known_types [NUM_SCALES] = '{TYPE_ACCEL, TYPE_GYRO, TYPE_ANGLE,
		TYPE_MAG, TYPE_QUAT};

	imu_frame_parser dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.rx_byte     (rx_byte),
		.empty       (empty),
		.pop         (pop),
		.status      (status),
		.kind        (kind),
		.value_zero  (value_zero),
		.value_one   (value_one),
		.value_two   (value_two),
		.value_three (value_three),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#(2_000_000);
		$display("imu_frame_parser_tb failed");
		$finish;
	end

	function automatic bit is_known(logic [7:0] t);
		foreach (known_types[i]) begin
			if (t == known_types[i])
				return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic logic [7:0] unknown_type();
		logic [7:0] t;
		do t = 8'($urandom) | TYPE_MASK; while (is_known(t));
		return t;
	endfunction

	function automatic frame_words_t random_words();
		frame_words_t w;
		for (int k = 0; k < NUM_WORDS; k++) begin
			case ($urandom_range(0, 7))
				0: w[k] = 16'h7FFF;
				1: w[k] = 16'h8000;
				2: w[k] = 16'h0000;
				3: w[k] = 16'hFFFF;
				default: w[k] = 16'($urandom);
			endcase
		end
		return w;
	endfunction

	function automatic frame_bytes_t make_frame(logic [7:0] type_byte, frame_words_t w,
			frame_fault_t fault);
		frame_bytes_t f;
		logic [7:0]   sum;
		f[0] = SYNC_BYTE;
		f[1] = type_byte;
		for (int k = 0; k < NUM_WORDS; k++) begin
			f[2 + 2*k] = w[k][7:0];
			f[3 + 2*k] = w[k][15:8];
		end
		case (fault)
			FAULT_SYNC: f[0] = SYNC_BYTE ^ 8'($urandom_range(1, 255));
			// clear one of the two required type bits
			FAULT_TYPE: f[1][$urandom_range(0, 1) ? 4 : 6] = 1'b0;
			default: ;
		endcase
		sum = '0;
		for (int i = 0; i < FRAME_LEN - 1; i++)
			sum += f[i];
		f[FRAME_LEN - 1] = (fault == FAULT_SUM) ? sum ^ 8'($urandom_range(1, 255)) : sum;
		return f;
	endfunction

	task automatic send_byte(logic [7:0] b);
		int gap;
		if (bytes_sent % 64 == 0)
			push_paced = ($urandom_range(0, 2) != 0);
		gap = push_paced ? $urandom_range(0, 4) : 0;
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (full);
		sb.note_byte(b);
		bytes_sent++;
	endtask

	task automatic send_frame(logic [7:0] type_byte, frame_words_t w, frame_fault_t fault);
		frame_bytes_t f;
		f = make_frame(type_byte, w, fault);
		for (int i = 0; i < FRAME_LEN; i++)
			send_byte(f[i]);
	endtask

	// indexes above REG_QUAT are unused and get random data the block must ignore
	task automatic write_scales(scale_set_t scales);
		logic [15:0] data;
		for (int i = REG_ACCEL; i < REG_SPACE; i++) begin
			data = (i < NUM_SCALES) ? scales[i] : 16'($urandom);
			cfg_valid <= 1'b1;
			cfg_index <= 3'(i);
			cfg_data <= data;
			do @(posedge clk); while (!cfg_ready);
			sb.set_scale(3'(i), data);
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic settle();
		int guard;
		push <= 1'b0;
		guard = 0;
		while (sb.expected_q.size() != 0 && guard < DRAIN_LIMIT) begin
			@(posedge clk);
			guard++;
		end
		// bytes that only fill the window may still be in flight
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.expected_q.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time, sb.expected_q.size());
			sb.failures += sb.expected_q.size();
			sb.expected_q.delete();
		end
	endtask

	task automatic directed_frames();
		send_frame(TYPE_ACCEL, {16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF}, FAULT_NONE);
		send_frame(TYPE_GYRO, {16'h8000, 16'h7FFF, 16'hFFFF, 16'h0000}, FAULT_NONE);
		send_frame(TYPE_ANGLE, random_words(), FAULT_NONE);
		send_frame(TYPE_MAG, {NUM_WORDS{16'h8000}}, FAULT_NONE);
		send_frame(TYPE_QUAT, {16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000}, FAULT_NONE);
		send_frame(TYPE_MASK, random_words(), FAULT_NONE);
		send_frame(TYPE_ALL_ONES, random_words(), FAULT_NONE);
		send_frame(TYPE_ACCEL, random_words(), FAULT_SUM);
		send_frame(TYPE_GYRO, random_words(), FAULT_SYNC);
		send_frame(TYPE_QUAT, random_words(), FAULT_TYPE);
		// resync on a clean frame after the broken ones
		send_frame(TYPE_QUAT, {NUM_WORDS{16'h7FFF}}, FAULT_NONE);
	endtask

	task automatic random_traffic(int n_bytes);
		int stop_at;
		int pick;
		stop_at = bytes_sent + n_bytes;
		while (bytes_sent < stop_at) begin
			pick = $urandom_range(0, 99);
			if (pick < 60) begin
				send_frame(known_types[$urandom_range(0, NUM_SCALES - 1)], random_words(),
					FAULT_NONE);
			end else if (pick < 68) begin
				send_frame(unknown_type(), random_words(), FAULT_NONE);
			end else if (pick < 85) begin
				send_frame(known_types[$urandom_range(0, NUM_SCALES - 1)], random_words(),
					frame_fault_t'($urandom_range(FAULT_SUM, FAULT_TYPE)));
			end else begin
				// noise with false sync bytes mixed in
				repeat ($urandom_range(1, 6))
					send_byte($urandom_range(0, 3) == 0 ? SYNC_BYTE : 8'($urandom));
			end
		end
	endtask

	initial begin : result_drain
		frame_result_t got;
		int            gap;
		int            popped;
		bit            paced;
		popped = 0;
		paced = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (popped % 64 == 0)
				paced = ($urandom_range(0, 2) != 0);
			gap = paced ? $urandom_range(0, 4) : 0;
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
			got.status = status;
			got.kind = kind;
			got.value[0] = value_zero;
			got.value[1] = value_one;
			got.value[2] = value_two;
			got.value[3] = value_three;
			sb.check_result(got);
			popped++;
		end
	end

	initial begin : stimulus
		scale_set_t scales;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		directed_frames();
		settle();
		for (int p = 0; p < NUM_PHASES; p++) begin
			foreach (scales[i]) begin
				case (p)
					0: scales[i] = 16'hFFFF;
					1: scales[i] = 16'h0000;
					default: scales[i] = ($urandom_range(0, 5) == 0) ? 16'hFFFF : 16'($urandom);
				endcase
			end
			write_scales(scales);
			if (p == 0)
				directed_frames();
			random_traffic(PHASE_BYTES);
			settle();
		end
		if (sb.failures == 0) begin
			$display("imu_frame_parser_tb passed");
		end else begin
			$display("imu_frame_parser_tb failed");
		end
		$finish;
	end

endmodule

>>> imu_frame_parser.f
sv/ifp_pkg.sv
sv/ifp_front.sv
sv/ifp_queue.sv
sv/ifp_back.sv
sv/imu_frame_parser.sv
verif/imu_frame_parser_tb.sv
